>>> sv/w3rmf_pkg.sv
package w3rmf_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COL_W     = 11;
    localparam int ROW_W     = 12;
    localparam int DIM_W     = 12;

    typedef enum logic [2:0] {
        MODE_MEDIAN = 3'd0,
        MODE_MEAN   = 3'd1,
        MODE_MIN    = 3'd2,
        MODE_MAX    = 3'd3,
        MODE_RANGE  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_RSHIFT = 3'd3,
        REG_GSHIFT = 3'd4,
        REG_BSHIFT = 3'd5,
        REG_AMASK  = 3'd6
    } reg_idx_t;

    typedef logic [7:0] chan_t;

    // One compare-exchange sorting network step on a pair.
    function automatic chan_t min8(input chan_t a, input chan_t b);
        min8 = (a < b) ? a : b;
    endfunction

    function automatic chan_t max8(input chan_t a, input chan_t b);
        max8 = (a < b) ? b : a;
    endfunction

endpackage

>>> sv/w3rmf_reduce.sv
module w3rmf_reduce (
    input  logic                  clk,
    input  logic                  en,
    input  logic [2:0]            mode,
    input  w3rmf_pkg::chan_t      v [9],
    output w3rmf_pkg::chan_t      result
);
    import w3rmf_pkg::*;

    // Stage 1: sort each column of three, plus running sum and extremes.
    chan_t     lo_next [3];
    chan_t     md_next [3];
    chan_t     hi_next [3];
    chan_t     lo_reg  [3];
    chan_t     md_reg  [3];
    chan_t     hi_reg  [3];
    logic [11:0] sum_next;
    logic [11:0] sum_reg;
    logic [2:0]  mode_reg;

    always_comb
    begin
        chan_t a;
        chan_t b;
        chan_t c;
        chan_t t;
        sum_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            a = v[k];
            b = v[k + 3];
            c = v[k + 6];
            t = min8(a, b); b = max8(a, b); a = t;
            t = min8(b, c); c = max8(b, c); b = t;
            t = min8(a, b); b = max8(a, b); a = t;
            lo_next[k] = a;
            md_next[k] = b;
            hi_next[k] = c;
        end
        for (int k = 0; k < 9; k++)
        begin
            sum_next = sum_next + {4'd0, v[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg   <= lo_next;
            md_reg   <= md_next;
            hi_reg   <= hi_next;
            sum_reg  <= sum_next;
            mode_reg <= mode;
        end
    end

    // Stage 2: median of max-of-mins, median-of-medians, min-of-maxes.
    chan_t       max_lo;
    chan_t       med_md;
    chan_t       min_hi;
    chan_t       all_lo;
    chan_t       all_hi;
    chan_t       median;
    logic [23:0] mean_prod;

    always_comb
    begin
        max_lo = max8(max8(lo_reg[0], lo_reg[1]), lo_reg[2]);
        min_hi = min8(min8(hi_reg[0], hi_reg[1]), hi_reg[2]);
        med_md = max8(min8(md_reg[0], md_reg[1]),
                      min8(max8(md_reg[0], md_reg[1]), md_reg[2]));
        median = max8(min8(max_lo, med_md), min8(max8(max_lo, med_md), min_hi));
        all_lo = min8(min8(lo_reg[0], lo_reg[1]), lo_reg[2]);
        all_hi = max8(max8(hi_reg[0], hi_reg[1]), hi_reg[2]);
        // sum / 9 for sum <= 2295: multiply by ceil(2^15 / 9).
        mean_prod = {12'd0, sum_reg} * 24'd3641;
        case (mode_reg)
            MODE_MEAN:  result = mean_prod[22:15];
            MODE_MIN:   result = all_lo;
            MODE_MAX:   result = all_hi;
            MODE_RANGE: result = all_hi - all_lo;
            default:    result = median;
        endcase
    end

endmodule

>>> sv/window_3x3_rank_mean_filter.sv
// 3x3 window rank / mean filter for a raster stream of packed 32-bit pixels.
// One pixel item is accepted per clock unless the pipe stalls. Two 2048-entry
// line stores (one synchronous memory each, registered read) and a 3x3
// window feed a two-stage reduction of each 8-bit channel: median, truncated
// mean (sum / 9), minimum, maximum or max minus min, chosen by the mode register.
// The centre pixel ANDed with alpha_mask is ORed into every result. An
// input at row r >= 2 and column c >= 2 yields the window centred at
// (r-1, c-1); border rows and columns repeat that value, so one input can
// produce up to nine result items, last_of_run marking the final one.
// Inner pixels flow at one item per cycle while the output is not blocked; a
// pixel that produces more than one result holds the input while they drain
// through the output register. The first result passes stages A, B and C and
// is then presented from the output register.
// Configuration may only be written while the block is idle.
module window_3x3_rank_mean_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] pixel_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_out,
    output logic [11:0] out_row,
    output logic [10:0] out_column,
    output logic        last_of_run
);
    import w3rmf_pkg::*;

    // Configuration registers.
    logic [2:0]  mode_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [4:0]  rsh_reg;
    logic [4:0]  gsh_reg;
    logic [4:0]  bsh_reg;
    logic [31:0] amask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MEDIAN;
            width_reg  <= 12'd2048;
            height_reg <= 12'd1080;
            rsh_reg    <= 5'd16;
            gsh_reg    <= 5'd8;
            bsh_reg    <= 5'd0;
            amask_reg  <= 32'hFF00_0000;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:   mode_reg   <= cfg_data[2:0];
                REG_WIDTH:  width_reg  <= cfg_data[11:0];
                REG_HEIGHT: height_reg <= cfg_data[11:0];
                REG_RSHIFT: rsh_reg    <= cfg_data[4:0];
                REG_GSHIFT: gsh_reg    <= cfg_data[4:0];
                REG_BSHIFT: bsh_reg    <= cfg_data[4:0];
                REG_AMASK:  amask_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic [11:0] eff_w;
    logic [11:0] eff_h;
    always_comb
    begin
        eff_w = width_reg;
        if (eff_w < 12'd3)
            eff_w = 12'd3;
        if (eff_w > 12'(MAX_WIDTH))
            eff_w = 12'(MAX_WIDTH);
        eff_h = (height_reg < 12'd3) ? 12'd3 : height_reg;
    end

    // Pipeline control: stage A (memory read), B (window), C (reduce 1),
    // D (reduce 2, fan-out of border copies).
    logic        stall;
    logic        acc;
    assign acc      = in_valid && in_ready;
    assign in_ready = !stall;

    // Position counters of the next input.
    logic [11:0] col_reg;
    logic [11:0] row_reg;
    logic [11:0] col_next;
    logic [11:0] row_next;
    always_comb
    begin
        col_next = col_reg + 12'd1;
        row_next = row_reg;
        if (col_next >= eff_w)
        begin
            col_next = '0;
            row_next = row_reg + 12'd1;
            if (row_next >= eff_h)
                row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line stores. The upper store takes the middle store's old word, so
    // both are read-modify-write at the same column address.
    logic [31:0] mem_up  [MAX_WIDTH];
    logic [31:0] mem_mid [MAX_WIDTH];
    logic [ADDR_W-1:0] addr;
    logic [31:0] up_q;
    logic [31:0] mid_q;
    assign addr = col_reg[ADDR_W-1:0];

    // Stage A registers.
    logic        a_v_reg;
    logic [31:0] a_pix_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [11:0] a_col_reg;
    logic [11:0] a_row_reg;

    // Forwarding: the next item can only read the same column when the
    // width is tiny, but a write in flight must still be seen.
    logic [31:0] up_fwd;
    logic [31:0] mid_fwd;
    logic        hit_reg;
    logic [31:0] hit_up_reg;
    logic [31:0] hit_mid_reg;
    assign up_fwd  = hit_reg ? hit_up_reg  : up_q;
    assign mid_fwd = hit_reg ? hit_mid_reg : mid_q;

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            up_q  <= mem_up[addr];
            mid_q <= mem_mid[addr];
        end
        // Write back happens after the read, when stage A is live and not stalled.
        if (a_v_reg && !stall)
        begin
            mem_up[a_addr_reg]  <= mid_fwd;
            mem_mid[a_addr_reg] <= a_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else if (!stall)
        begin
            a_v_reg <= acc;
            hit_reg <= acc && a_v_reg && (a_addr_reg == addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            a_pix_reg   <= pixel_word;
            a_addr_reg  <= addr;
            a_col_reg   <= col_reg;
            a_row_reg   <= row_reg;
            hit_up_reg  <= mid_fwd;
            hit_mid_reg <= a_pix_reg;
        end
    end

    // Stage B: window shift.
    logic [31:0] win_reg [9];
    logic        b_v_reg;
    logic [11:0] b_col_reg;
    logic [11:0] b_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
            b_v_reg <= 1'b0;
        end
        else if (!stall)
        begin
            b_v_reg <= a_v_reg;
            if (a_v_reg)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= up_fwd;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= mid_fwd;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= a_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            b_col_reg <= a_col_reg;
            b_row_reg <= a_row_reg;
        end
    end

    // Stage C: first reduction stage inside the channel units.
    logic        c_v_reg;
    logic        c_gen_reg;
    logic [11:0] c_col_reg;
    logic [11:0] c_row_reg;
    logic [31:0] c_alpha_reg;
    logic [4:0]  sh [3];
    chan_t       ch_v [3][9];
    chan_t       ch_res [3];

    assign sh[0] = rsh_reg;
    assign sh[1] = gsh_reg;
    assign sh[2] = bsh_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            for (int k = 0; k < 9; k++)
                ch_v[c][k] = chan_t'(win_reg[k] >> sh[c]);
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        w3rmf_reduce u_reduce (
            .clk    (clk),
            .en     (!stall),
            .mode   (mode_reg),
            .v      (ch_v[c]),
            .result (ch_res[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (!stall)
            c_v_reg <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            c_gen_reg   <= (b_row_reg >= 12'd2) && (b_col_reg >= 12'd2);
            c_col_reg   <= b_col_reg - 12'd1;
            c_row_reg   <= b_row_reg - 12'd1;
            c_alpha_reg <= win_reg[4] & amask_reg;
        end
    end

    // Stage D: assemble the result and walk the border copies.
    logic [31:0] res;
    always_comb
    begin
        res = c_alpha_reg
            | (32'(ch_res[0]) << rsh_reg)
            | (32'(ch_res[1]) << gsh_reg)
            | (32'(ch_res[2]) << bsh_reg);
    end

    // Row and column run: up to three rows times three columns.
    logic        extra_r0;
    logic        extra_r1;
    logic        extra_c0;
    logic        extra_c1;
    assign extra_r0 = (c_row_reg == 12'd1);
    assign extra_r1 = (c_row_reg == eff_h - 12'd2);
    assign extra_c0 = (c_col_reg == 12'd1);
    assign extra_c1 = (c_col_reg == eff_w - 12'd2);

    logic [1:0] ri_reg;
    logic [1:0] ci_reg;
    logic [1:0] ri_next;
    logic [1:0] ci_next;
    logic [11:0] cur_row;
    logic [11:0] cur_col;
    logic        row_last;
    logic        col_last;
    logic        run_last;

    always_comb
    begin
        case (ri_reg)
            2'd0:    cur_row = extra_r0 ? 12'd0 : c_row_reg;
            2'd1:    cur_row = extra_r0 ? c_row_reg : eff_h - 12'd1;
            default: cur_row = eff_h - 12'd1;
        endcase
        case (ci_reg)
            2'd0:    cur_col = extra_c0 ? 12'd0 : c_col_reg;
            2'd1:    cur_col = extra_c0 ? c_col_reg : eff_w - 12'd1;
            default: cur_col = eff_w - 12'd1;
        endcase
        row_last = (ri_reg == 2'({1'b0, extra_r0} + {1'b0, extra_r1}));
        col_last = (ci_reg == 2'({1'b0, extra_c0} + {1'b0, extra_c1}));
        run_last = row_last && col_last;
        ri_next  = ri_reg;
        ci_next  = ci_reg;
        if (col_last)
        begin
            ci_next = '0;
            ri_next = row_last ? 2'd0 : ri_reg + 2'd1;
        end
        else
        begin
            ci_next = ci_reg + 2'd1;
        end
    end

    logic d_live;
    logic out_free;
    assign d_live   = c_v_reg && c_gen_reg;
    assign out_free = !out_valid || out_ready;
    // Hold the pipe while the output is blocked or a run is not finished.
    assign stall    = d_live && (!out_free || !run_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ri_reg    <= '0;
            ci_reg    <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_free)
                out_valid <= d_live;
            if (d_live && out_free)
            begin
                ri_reg <= ri_next;
                ci_reg <= ci_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_live && out_free)
        begin
            pixel_out   <= res;
            out_row     <= cur_row;
            out_column  <= cur_col[10:0];
            last_of_run <= run_last;
        end
    end

endmodule
